[rtl/wts_pkg.sv]
// Package for the weighted target selector: field widths, register indexes,
// register reset values and the structs passed between the modules.
// No dependencies.
`timescale 1ns / 1ps

package wts_pkg;

  localparam int COORD_FRAC_BITS_DEF = 4;
  localparam int WEIGHT_WIDTH_DEF    = 40;

  localparam int COORD_W  = 16;
  localparam int DGAIN_W  = 20;
  localparam int SGAIN_W  = 12;
  localparam int CENTER_W = 12;
  localparam int OFFSET_W = 13;
  localparam int CFG_IDX_W = 2;

  localparam logic [DGAIN_W-1:0]  DGAIN_RST    = DGAIN_W'(80000);
  localparam logic [SGAIN_W-1:0]  SGAIN_RST    = SGAIN_W'(192);
  localparam logic [CENTER_W-1:0] CENTER_X_RST = CENTER_W'(320);
  localparam logic [CENTER_W-1:0] CENTER_Y_RST = CENTER_W'(240);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DISTANCE_GAIN = 2'd0,
    REG_SIZE_GAIN     = 2'd1,
    REG_CENTER_X      = 2'd2,
    REG_CENTER_Y      = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [DGAIN_W-1:0] distance_gain;
    logic [SGAIN_W-1:0] size_gain;
  } gain_cfg_t;

  // One weight calculation: distances to the reference and the blob size.
  typedef struct packed {
    logic               start;
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
    logic [COORD_W-1:0] blob_size;
  } weight_job_t;

endpackage

[rtl/wts_weight_unit.sv]
// Iterative weight calculator: one shared 16x16 multiplier, a bit-serial
// square root and a restoring divider under a small sequencer.
// Depends on wts_pkg.
`timescale 1ns / 1ps

module wts_weight_unit import wts_pkg::*; #(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
  parameter int WEIGHT_WIDTH    = WEIGHT_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  gain_cfg_t               gains,
  input  weight_job_t             job,
  output logic                    done,
  output logic [WEIGHT_WIDTH-1:0] weight
);

  localparam int SQ_W    = 2 * COORD_W + 1;
  localparam int SH_W    = SQ_W + 1;
  localparam int ROOT_W  = SH_W / 2;
  localparam int REM_W   = ROOT_W + 2;
  localparam int T_W     = REM_W + 2;
  localparam int SHIFT   = 2 * COORD_FRAC_BITS + 8;
  localparam int NUM_W   = DGAIN_W + SHIFT;
  localparam int PROD_W  = 2 * COORD_W;
  localparam int SZT_W   = SGAIN_W + COORD_W;
  localparam int SUM_W   = NUM_W + 1;
  localparam int CMP_W   = (SUM_W > WEIGHT_WIDTH) ? SUM_W : WEIGHT_WIDTH;
  localparam int CNT_W   = $clog2(NUM_W);

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL_X, ST_MUL_Y, ST_MUL_S, ST_SQRT, ST_DIV, ST_SUM
  } wstate_t;

  wstate_t            state;
  logic [COORD_W-1:0] dx, dy, blob_size;
  logic [SQ_W-1:0]    sq;
  logic [SZT_W-1:0]   size_term;
  logic               zero_dist;
  logic [SH_W-1:0]    sh;
  logic [REM_W-1:0]   rem;
  logic [ROOT_W-1:0]  root;
  logic [NUM_W-1:0]   num;
  logic [ROOT_W-1:0]  drem;
  logic [CNT_W-1:0]   cnt;

  logic [COORD_W-1:0] mul_a, mul_b;
  logic [PROD_W-1:0]  prod;
  logic [T_W-1:0]     sq_t, sq_trial;
  logic               sq_ge;
  logic [ROOT_W:0]    dv_t;
  logic               dv_ge;
  logic [CMP_W-1:0]   sum_ext;
  logic [CMP_W-1:0]   wmax_ext;

  always_comb begin
    case (state)
      ST_MUL_X: begin mul_a = dx; mul_b = dx; end
      ST_MUL_Y: begin mul_a = dy; mul_b = dy; end
      ST_MUL_S: begin mul_a = COORD_W'(gains.size_gain); mul_b = blob_size; end
      default:  begin mul_a = dx; mul_b = dy; end
    endcase
  end

  assign prod = mul_a * mul_b;

  // Square root digit step: bring down two bits, try (root << 2) | 1.
  assign sq_t     = {rem, sh[SH_W-1 -: 2]};
  assign sq_trial = T_W'({root, 2'b01});
  assign sq_ge    = sq_t >= sq_trial;

  // Division step: bring down one numerator bit, compare with the root.
  assign dv_t  = {drem, num[NUM_W-1]};
  assign dv_ge = dv_t >= {1'b0, root};

  assign sum_ext  = CMP_W'(num) + CMP_W'(size_term);
  assign wmax_ext = CMP_W'({WEIGHT_WIDTH{1'b1}});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= (state == ST_SUM);
      case (state)
        ST_IDLE: begin
          if (job.start) begin
            dx        <= job.dx;
            dy        <= job.dy;
            blob_size <= job.blob_size;
            state     <= ST_MUL_X;
          end
        end
        ST_MUL_X: begin
          sq    <= SQ_W'(prod);
          state <= ST_MUL_Y;
        end
        ST_MUL_Y: begin
          sq    <= sq + SQ_W'(prod);
          state <= ST_MUL_S;
        end
        ST_MUL_S: begin
          size_term <= SZT_W'(prod);
          zero_dist <= (sq == '0);
          sh        <= SH_W'(sq);
          rem       <= '0;
          root      <= '0;
          cnt       <= '0;
          state     <= (sq == '0) ? ST_SUM : ST_SQRT;
        end
        ST_SQRT: begin
          sh   <= sh << 2;
          rem  <= sq_ge ? REM_W'(sq_t - sq_trial) : REM_W'(sq_t);
          root <= {root[ROOT_W-2:0], sq_ge};
          if (cnt == CNT_W'(ROOT_W - 1)) begin
            num   <= NUM_W'(gains.distance_gain) << SHIFT;
            drem  <= '0;
            cnt   <= '0;
            state <= ST_DIV;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_DIV: begin
          drem <= dv_ge ? ROOT_W'(dv_t - {1'b0, root}) : dv_t[ROOT_W-1:0];
          num  <= {num[NUM_W-2:0], dv_ge};
          cnt  <= cnt + 1'b1;
          if (cnt == CNT_W'(NUM_W - 1)) begin
            state <= ST_SUM;
          end
        end
        ST_SUM: begin
          if (zero_dist || (sum_ext > wmax_ext)) begin
            weight <= {WEIGHT_WIDTH{1'b1}};
          end else begin
            weight <= sum_ext[WEIGHT_WIDTH-1:0];
          end
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[rtl/weighted_target_select.sv]
// Weighted target selector. A blob item runs through the weight unit's
// one-bit-a-cycle square root and divider; a blob at the reference skips both.
// An item without a blob is taken in the idle state; a frame end passes through
// an emit state that loads the output register, which decouples the result
// from the next item.
// Synchronous reset restores the register defaults and clears the state machines, reference, best blob and valid.
`timescale 1ns / 1ps

module weighted_target_select import wts_pkg::*; #(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
  parameter int WEIGHT_WIDTH    = WEIGHT_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [47:0]          s_tdata,   // pos_x, pos_y, blob_size
  input  logic                 s_tuser,   // has_blob
  input  logic                 s_tlast,   // frame_end
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [63:0]          m_tdata,   // target_x, target_y, offset_x, offset_y, zero fill
  output logic                 m_tuser,   // found
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DGAIN_W-1:0]   cfg_data
);

  localparam int DIFF_W = (((CENTER_W + COORD_FRAC_BITS) > COORD_W) ?
                           (CENTER_W + COORD_FRAC_BITS) : COORD_W) + 2;

  typedef enum logic [1:0] {ST_IDLE, ST_BUSY, ST_EMIT} state_t;

  state_t                  state;
  gain_cfg_t               gains;
  logic [CENTER_W-1:0]     center_x, center_y;
  logic [COORD_W-1:0]      ref_x, ref_y, best_x, best_y;
  logic [COORD_W-1:0]      cur_x, cur_y;
  logic [WEIGHT_WIDTH-1:0] best_weight;
  logic                    last;
  weight_job_t             job;
  logic                    w_done;
  logic [WEIGHT_WIDTH-1:0] w_value;

  logic [COORD_W-1:0] in_x, in_y, in_size;
  logic               s_fire;
  logic [OFFSET_W-1:0] off_x, off_y;

  function automatic logic [OFFSET_W-1:0] offset_calc(input logic [COORD_W-1:0] t,
                                                      input logic [CENTER_W-1:0] c);
    logic signed [DIFF_W-1:0] diff;
    logic signed [DIFF_W-1:0] adj;
    logic signed [DIFF_W-1:0] q;
    diff = $signed(DIFF_W'(t) - (DIFF_W'(c) << COORD_FRAC_BITS));
    // Arithmetic shift floors; bias negative values so the result truncates.
    adj  = diff + ((diff < 0) ? $signed(DIFF_W'((1 << COORD_FRAC_BITS) - 1))
                              : $signed(DIFF_W'(0)));
    q    = adj >>> COORD_FRAC_BITS;
    if (q < $signed(-DIFF_W'(4096))) begin
      q = -DIFF_W'(4096);
    end else if (q > $signed(DIFF_W'(4095))) begin
      q = DIFF_W'(4095);
    end
    return q[OFFSET_W-1:0];
  endfunction

  assign in_x     = s_tdata[15:0];
  assign in_y     = s_tdata[31:16];
  assign in_size  = s_tdata[47:32];
  assign s_tready = (state == ST_IDLE);
  assign s_fire   = s_tvalid && s_tready;
  assign off_x    = offset_calc(best_x, center_x);
  assign off_y    = offset_calc(best_y, center_y);

  always_comb begin
    job.start     = s_fire && s_tuser;
    job.dx        = (in_x >= ref_x) ? (in_x - ref_x) : (ref_x - in_x);
    job.dy        = (in_y >= ref_y) ? (in_y - ref_y) : (ref_y - in_y);
    job.blob_size = in_size;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gains.distance_gain <= DGAIN_RST;
      gains.size_gain     <= SGAIN_RST;
      center_x            <= CENTER_X_RST;
      center_y            <= CENTER_Y_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DISTANCE_GAIN: gains.distance_gain <= cfg_data;
        REG_SIZE_GAIN:     gains.size_gain     <= cfg_data[SGAIN_W-1:0];
        REG_CENTER_X:      center_x            <= cfg_data[CENTER_W-1:0];
        REG_CENTER_Y:      center_y            <= cfg_data[CENTER_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      ref_x       <= '0;
      ref_y       <= '0;
      best_x      <= '0;
      best_y      <= '0;
      best_weight <= '0;
      last        <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      // In the emit state the output register is reloaded below instead.
      if (m_tvalid && m_tready && (state != ST_EMIT)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_fire) begin
            cur_x <= in_x;
            cur_y <= in_y;
            last  <= s_tlast;
            if (s_tuser) begin
              state <= ST_BUSY;
            end else if (s_tlast) begin
              state <= ST_EMIT;
            end
          end
        end
        ST_BUSY: begin
          if (w_done) begin
            // Strictly greater only, so the earlier blob keeps a tie.
            if (w_value > best_weight) begin
              best_weight <= w_value;
              best_x      <= cur_x;
              best_y      <= cur_y;
            end
            state <= last ? ST_EMIT : ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid    <= 1'b1;
            m_tuser     <= (best_weight != '0);
            m_tdata     <= {6'b0, off_y, off_x, best_y, best_x};
            ref_x       <= best_x;
            ref_y       <= best_y;
            best_x      <= '0;
            best_y      <= '0;
            best_weight <= '0;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  wts_weight_unit #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS),
    .WEIGHT_WIDTH    (WEIGHT_WIDTH)
  ) u_weight (
    .clk    (clk),
    .rst    (rst),
    .gains  (gains),
    .job    (job),
    .done   (w_done),
    .weight (w_value)
  );

endmodule

[sim/weighted_target_select_tb.sv]
// Self-checking testbench for weighted_target_select: streams blob items with
// random idling on both sides and checks every target item against a predictor.
// Depends on wts_pkg and the weighted_target_select RTL.
`timescale 1ns / 1ps

module weighted_target_select_tb;
  import wts_pkg::*;

  localparam int CF = COORD_FRAC_BITS_DEF;
  localparam int WW = WEIGHT_WIDTH_DEF;
  localparam logic [63:0] WEIGHT_MAX = (64'd1 << WW) - 64'd1;
  localparam int IDLE_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 100;

  typedef struct {
    logic                        found;
    logic [COORD_W-1:0]          tx;
    logic [COORD_W-1:0]          ty;
    logic signed [OFFSET_W-1:0]  ox;
    logic signed [OFFSET_W-1:0]  oy;
  } target_t;

  // Tracks the reference point and the best blob of the current frame, and
  // holds the target items still owed by the block.
  class winner_tracker;
    logic [DGAIN_W-1:0]  dist_gain;
    logic [SGAIN_W-1:0]  size_gain;
    logic [CENTER_W-1:0] cen_x;
    logic [CENTER_W-1:0] cen_y;
    logic [COORD_W-1:0]  ref_x;
    logic [COORD_W-1:0]  ref_y;
    logic [COORD_W-1:0]  best_x;
    logic [COORD_W-1:0]  best_y;
    logic [63:0]         best_w;
    target_t             winner_q[$];
    int                  errors;

    function new();
      dist_gain = DGAIN_RST;
      size_gain = SGAIN_RST;
      cen_x     = CENTER_X_RST;
      cen_y     = CENTER_Y_RST;
      ref_x     = '0;
      ref_y     = '0;
      best_x    = '0;
      best_y    = '0;
      best_w    = '0;
      errors    = 0;
    endfunction

    function void set_config(logic [DGAIN_W-1:0] dg, logic [SGAIN_W-1:0] sg,
                             logic [CENTER_W-1:0] cx, logic [CENTER_W-1:0] cy);
      dist_gain = dg;
      size_gain = sg;
      cen_x     = cx;
      cen_y     = cy;
    endfunction

    function int pending();
      return winner_q.size();
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    // Offset in whole pixels, truncated toward zero and clamped to the field.
    function logic signed [OFFSET_W-1:0] pixel_offset(logic [COORD_W-1:0] t,
                                                      logic [CENTER_W-1:0] c);
      longint diff, q;
      diff = longint'({48'd0, t}) - (longint'({52'd0, c}) << CF);
      q = diff / (longint'(1) << CF);
      if (q < -4096) q = -4096;
      if (q > 4095) q = 4095;
      return q[OFFSET_W-1:0];
    endfunction

    function void note_item(bit has, logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
                            logic [COORD_W-1:0] sz, bit last);
      logic [COORD_W-1:0] ddx, ddy;
      logic [63:0] dx, dy, sq, root, cand, dterm, w;
      target_t want;
      if (has) begin
        ddx = (px > ref_x) ? px - ref_x : ref_x - px;
        ddy = (py > ref_y) ? py - ref_y : ref_y - py;
        dx = {48'd0, ddx};
        dy = {48'd0, ddy};
        sq = dx * dx + dy * dy;
        if (sq == 0) begin
          w = WEIGHT_MAX;
        end else begin
          // Integer square root, one result bit at a time.
          root = '0;
          for (int i = 20; i >= 0; i--) begin
            cand = root | (64'd1 << i);
            if (cand * cand <= sq) root = cand;
          end
          dterm = ({44'd0, dist_gain} << (2 * CF + 8)) / root;
          w = dterm + {52'd0, size_gain} * {48'd0, sz};
          if (w > WEIGHT_MAX) w = WEIGHT_MAX;
        end
        if (w > best_w) begin
          best_w = w;
          best_x = px;
          best_y = py;
        end
      end
      if (last) begin
        want.found = (best_w != 0);
        want.tx    = best_x;
        want.ty    = best_y;
        want.ox    = pixel_offset(best_x, cen_x);
        want.oy    = pixel_offset(best_y, cen_y);
        winner_q.insert(winner_q.size(), want);
        ref_x  = best_x;
        ref_y  = best_y;
        best_x = '0;
        best_y = '0;
        best_w = '0;
      end
    endfunction

    task check_winner(target_t got);
      target_t want;
      if (winner_q.size() == 0) begin
        report_mismatch($sformatf("target item with none pending: found=%0d x=%0d y=%0d",
                                  got.found, got.tx, got.ty));
      end else begin
        want = winner_q.pop_front();
        if (got.found !== want.found || got.tx !== want.tx || got.ty !== want.ty ||
            got.ox !== want.ox || got.oy !== want.oy) begin
          report_mismatch($sformatf(
            "got found=%0d x=%0d y=%0d ox=%0d oy=%0d, want found=%0d x=%0d y=%0d ox=%0d oy=%0d",
            got.found, got.tx, got.ty, got.ox, got.oy,
            want.found, want.tx, want.ty, want.ox, want.oy));
        end
      end
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [47:0]          s_tdata = '0;   // pos_x, pos_y, blob_size
  logic                 s_tuser = 1'b0; // has_blob
  logic                 s_tlast = 1'b0; // frame_end
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [63:0]          m_tdata;        // target_x, target_y, offset_x, offset_y, zero fill
  logic                 m_tuser;        // found
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DGAIN_W-1:0]   cfg_data = '0;

  winner_tracker sb = new();
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  int rx_hold = 0;
  int idle_cycles = 0;

  always #6 clk = ~clk;

  weighted_target_select u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Receiver back-pressure: mostly short stalls, now and then a long one.
  always @(posedge clk) begin
    int r;
    if (rx_hold != 0) begin
      rx_hold--;
    end else if (rx_calm) begin
      m_tready <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b0;
        rx_hold = (r < 95) ? $urandom_range(0, 3) : $urandom_range(20, 80);
      end
    end
  end

  always @(posedge clk) begin
    target_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.found = m_tuser;
      got.tx    = m_tdata[15:0];
      got.ty    = m_tdata[31:16];
      got.ox    = m_tdata[44:32];
      got.oy    = m_tdata[57:45];
      sb.check_winner(got);
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("weighted_target_select regression: fail");
      $finish;
    end
  end

  // Presents one item and returns in the step where it is accepted, leaving
  // tvalid high so that a following item can go out without a bubble.
  task automatic send_item(bit has, logic [15:0] px, logic [15:0] py,
                           logic [15:0] sz, bit last);
    int gap, r;
    r = $urandom_range(0, 99);
    if (tx_calm || r < 55) gap = 0;
    else if (r < 93) gap = $urandom_range(1, 4);
    else gap = $urandom_range(15, 60);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {sz, py, px};
    s_tuser  <= has;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    sb.note_item(has, px, py, sz, last);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic program_regs(logic [DGAIN_W-1:0] dg, logic [SGAIN_W-1:0] sg,
                              logic [CENTER_W-1:0] cx, logic [CENTER_W-1:0] cy);
    cfg_we    <= 1'b1;
    cfg_index <= REG_DISTANCE_GAIN;
    cfg_data  <= dg;
    @(posedge clk);
    cfg_index <= REG_SIZE_GAIN;
    cfg_data  <= DGAIN_W'(sg);
    @(posedge clk);
    cfg_index <= REG_CENTER_X;
    cfg_data  <= DGAIN_W'(cx);
    @(posedge clk);
    cfg_index <= REG_CENTER_Y;
    cfg_data  <= DGAIN_W'(cy);
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_config(dg, sg, cx, cy);
  endtask

  // Random frames of a few blobs each, with empty frames and ignored items
  // mixed in. Blobs often sit at or near the reference to reach the short
  // distances and the saturated weight.
  task automatic random_frames(int n_items);
    int done, nb, k;
    bit end_on_blob;
    logic [15:0] px, py, sz;
    done = 0;
    px = '0;
    py = '0;
    sz = '0;
    while (done < n_items) begin
      nb = ($urandom_range(0, 99) < 8) ? 0 : $urandom_range(1, 4);
      end_on_blob = (nb != 0) && ($urandom_range(0, 1) == 1);
      for (int i = 0; i < nb; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_item(1'b0, 16'($urandom), 16'($urandom), 16'($urandom), 1'b0);
        end
        k = $urandom_range(0, 99);
        if (k < 60) begin
          px = 16'($urandom);
          py = 16'($urandom);
        end else if (k < 80) begin
          px = sb.ref_x + 16'($urandom_range(0, 30)) - 16'd15;
          py = sb.ref_y + 16'($urandom_range(0, 30)) - 16'd15;
        end else if (k < 90) begin
          px = sb.ref_x;
          py = sb.ref_y;
        end else if (k >= 95) begin
          px = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
          py = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
        end
        // Between 90 and 94 the previous blob is sent again, size and all.
        if (k < 90 || k >= 95) begin
          sz = ($urandom_range(0, 1) == 1) ? 16'($urandom) : 16'($urandom_range(0, 255));
        end
        send_item(1'b1, px, py, sz, end_on_blob && (i == nb - 1));
        done++;
      end
      if (!end_on_blob) begin
        send_item(1'b0, 16'($urandom), 16'($urandom), 16'($urandom), 1'b1);
        done++;
      end
      if ($urandom_range(0, 24) == 0) drain_results();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // The reference starts at the origin, so this blob gets the saturated weight.
    send_item(1'b1, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_item(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    send_item(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    send_item(1'b0, 16'h1234, 16'h5678, 16'h9ABC, 1'b0);
    send_item(1'b1, 16'd1600, 16'd1600, 16'd160, 1'b1);
    // Two blobs at equal distance either side with equal size: the first stays.
    send_item(1'b1, 16'd1760, 16'd1600, 16'd100, 1'b0);
    send_item(1'b1, 16'd1440, 16'd1600, 16'd100, 1'b0);
    send_item(1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b1);
    send_item(1'b1, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b0);
    send_item(1'b1, 16'h0000, 16'hFFFF, 16'h0000, 1'b0);
    send_item(1'b1, 16'd1761, 16'd1600, 16'd0, 1'b1);
    send_item(1'b1, 16'd1761, 16'd1600, 16'hFFFF, 1'b1);
    // Offsets with a fraction of a pixel either side of the centre.
    send_item(1'b1, 16'd5113, 16'd3847, 16'd8, 1'b1);
    send_item(1'b1, 16'd5100, 16'd3860, 16'd8, 1'b1);
    random_frames(115);

    for (int p = 1; p <= 6; p++) begin
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clk);
      case (p)
        1: program_regs('0, '0, '0, '0);
        2: program_regs('1, '1, '1, '1);
        3: program_regs('1, '0, '0, '0);
        4: program_regs('0, '1, CENTER_W'($urandom), CENTER_W'($urandom));
        default: program_regs(DGAIN_W'($urandom), SGAIN_W'($urandom),
                              CENTER_W'($urandom), CENTER_W'($urandom));
      endcase
      tx_calm = (p == 2);
      rx_calm <= (p == 2 || p == 5);
      case (p)
        1: begin
          // With both gains at zero only a blob at the reference can win.
          send_item(1'b1, sb.ref_x + 16'd100, sb.ref_y, 16'hFFFF, 1'b1);
          send_item(1'b1, 16'h0000, 16'h0000, 16'h0000, 1'b0);
          send_item(1'b1, 16'h0000, 16'h0000, 16'hFFFF, 1'b1);
        end
        2: send_item(1'b1, 16'h0000, 16'h0000, 16'hFFFF, 1'b1);
        3: send_item(1'b1, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b1);
        default: ;
      endcase
      random_frames(115);
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.report_mismatch($sformatf("%0d target items never arrived", sb.pending()));
    end
    if (sb.errors == 0) begin
      $display("weighted_target_select regression: pass");
    end else begin
      $display("weighted_target_select regression: fail");
    end
    $finish;
  end

endmodule
